FILE: hw/rtl/swbi_pkg.sv
// Shared operation codes and constants for the stack with bulk increment.
`default_nettype none

package swbi_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_INC  = 2'd2;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned COUNT_IW = 11;

  localparam logic [CFG_W-1:0]   MAX_SIZE_RESET = 11'd1024;
  localparam logic [FIELD_W-1:0] EMPTY_POP      = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

FILE: hw/rtl/stack_with_bulk_increment.sv
// Bounded LIFO stack with lazy add-to-bottom-k increment, memory based.
//
// Input channel (in_*): one request per item, accepted when in_valid is high
// and in_stall is low. in_operation selects push, pop or increment.
// Result channel (out_*): exactly one result per request, in request order,
// taken when out_valid is high and out_stall is low.
// Configuration: cfg_wr_en writes cfg_wr_data into the max_size register.
// Results: push, empty pop, increment and unused codes give their result in
// the cycle after acceptance; a pop of a held entry passes through S_POP_RD
// before its result is registered. in_stall is high in S_WR for an increment
// and in S_POP_RD, then S_WR if an entry lies below the popped one, for a pop.
// The pending-add memory's single write port sets these states: a pop reads
// the popped slot, then reads and writes the slot below; an increment reads
// then writes one slot. Other requests enter no busy state.
// Reset empties the stack and sets max_size to 1024; no clearing pass runs,
// since a push zeroes the pending slot of the entry it creates.
// A stalled result holds in the output register; a new request is taken
// only once that register is free or being emptied in the same cycle.
`default_nettype none

module stack_with_bulk_increment #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [swbi_pkg::CFG_W-1:0]             cfg_wr_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [1:0]                             in_operation,
  input  wire logic signed [swbi_pkg::FIELD_W-1:0]    in_push_value,
  input  wire logic [swbi_pkg::COUNT_IW-1:0]          in_increment_count,
  input  wire logic signed [swbi_pkg::FIELD_W-1:0]    in_increment_amount,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [swbi_pkg::FIELD_W-1:0]         out_pop_value,
  output logic                                        out_was_empty,
  output logic                                        out_push_dropped
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_POP_RD, S_WR} state_t;

  logic [DATA_WIDTH-1:0] value_mem [DEPTH];
  logic [DATA_WIDTH-1:0] pend_mem  [DEPTH];

  state_t                       state_r;
  logic [CW-1:0]                count_r;
  logic [swbi_pkg::CFG_W-1:0]   max_size_r;
  logic [AW-1:0]                top_r;
  logic [DATA_WIDTH-1:0]        add_r;
  logic [DATA_WIDTH-1:0]        val_rd_r;
  logic [DATA_WIDTH-1:0]        pend_rd_r;
  logic                         out_valid_r;
  logic [swbi_pkg::FIELD_W-1:0] out_pop_value_r;
  logic                         out_was_empty_r;
  logic                         out_push_dropped_r;

  logic                  accept;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         top_idx;
  logic [AW-1:0]         cnt_idx;
  logic                  can_push;
  logic [31:0]           k_m1;
  logic [AW-1:0]         inc_at;
  logic                  inc_live;
  logic [AW-1:0]         pend_raddr;
  logic                  pend_we;
  logic [AW-1:0]         pend_waddr;
  logic [DATA_WIDTH-1:0] pend_wdata;
  logic                  val_we;
  logic [DATA_WIDTH-1:0] pop_sum;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign cnt_m1   = count_r - 1'b1;
  assign top_idx  = cnt_m1[AW-1:0];
  assign cnt_idx  = count_r[AW-1:0];
  assign can_push = (32'(count_r) < 32'(max_size_r)) && (32'(count_r) < DEPTH);
  assign k_m1     = 32'(in_increment_count) - 32'd1;
  assign inc_at   = (k_m1 < 32'(top_idx)) ? AW'(k_m1) : top_idx;
  assign inc_live = (in_increment_count != '0) && (count_r != '0);
  assign pop_sum  = val_rd_r + pend_rd_r;

  assign val_we = accept && (in_operation == swbi_pkg::OP_PUSH) && can_push;

  always_comb begin
    unique case (state_r)
      S_IDLE:   pend_raddr = (in_operation == swbi_pkg::OP_INC) ? inc_at : top_idx;
      S_POP_RD: pend_raddr = top_r - 1'b1;
      default:  pend_raddr = top_r;
    endcase
  end

  always_comb begin
    pend_we    = 1'b0;
    pend_waddr = cnt_idx;
    pend_wdata = '0;
    if (val_we) begin
      pend_we = 1'b1;
    end else if (state_r == S_WR) begin
      pend_we    = 1'b1;
      pend_waddr = top_r;
      pend_wdata = pend_rd_r + add_r;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[cnt_idx] <= DATA_WIDTH'(in_push_value);
    end
    val_rd_r <= value_mem[top_idx];
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    pend_rd_r <= pend_mem[pend_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_size_r  <= swbi_pkg::MAX_SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        max_size_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_valid_r        <= 1'b1;
            out_pop_value_r    <= '0;
            out_was_empty_r    <= 1'b0;
            out_push_dropped_r <= 1'b0;
            case (in_operation)
              swbi_pkg::OP_PUSH: begin
                if (can_push) begin
                  count_r <= count_r + 1'b1;
                end else begin
                  out_push_dropped_r <= 1'b1;
                end
              end
              swbi_pkg::OP_POP: begin
                if (count_r == '0) begin
                  out_pop_value_r <= swbi_pkg::EMPTY_POP;
                  out_was_empty_r <= 1'b1;
                end else begin
                  out_valid_r <= 1'b0;
                  count_r     <= cnt_m1;
                  top_r       <= top_idx;
                  state_r     <= S_POP_RD;
                end
              end
              swbi_pkg::OP_INC: begin
                if (inc_live) begin
                  top_r   <= inc_at;
                  add_r   <= DATA_WIDTH'(in_increment_amount);
                  state_r <= S_WR;
                end
              end
              default: ;
            endcase
          end
        end
        S_POP_RD: begin
          out_valid_r        <= 1'b1;
          out_pop_value_r    <= 32'(pop_sum);
          out_was_empty_r    <= 1'b0;
          out_push_dropped_r <= 1'b0;
          add_r              <= pend_rd_r;
          top_r              <= top_r - 1'b1;
          state_r            <= (top_r != '0) ? S_WR : S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pop_value    = out_pop_value_r;
  assign out_was_empty    = out_was_empty_r;
  assign out_push_dropped = out_push_dropped_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("stack fill above depth");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_was_empty_r |->
      (out_pop_value_r == swbi_pkg::EMPTY_POP) && !out_push_dropped_r)
    else $error("empty pop result malformed");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && val_we |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not raise fill");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_RD |-> !out_valid_r)
    else $error("pop result would overwrite pending result");

endmodule

`default_nettype wire
